FILE: src/nv2rgb_pkg.sv
`default_nettype none

package nv2rgb_pkg;

    // field widths fixed by the pixel format
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CFG_W   = 12;
    localparam int unsigned INDEX_W = 22;

    // register map of the configuration port
    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT  = 2'd1,
        CFG_MIRROR_ENABLE = 2'd2
    } cfg_index_t;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;
    localparam logic             MIRROR_RESET       = 1'b1;

    // offsets and fixed-point chroma coefficients (scaled by 256)
    localparam logic [7:0] LUMA_OFFSET   = 8'd16;
    localparam logic [8:0] CHROMA_OFFSET = 9'd128;
    localparam logic [7:0] K_V_RED       = 8'd103;
    localparam logic [7:0] K_V_GREEN     = 8'd183;
    localparam logic [7:0] K_U_GREEN     = 8'd88;
    localparam logic [7:0] K_U_BLUE      = 8'd198;
    localparam logic [7:0] BYTE_MAX      = 8'd255;

    // signed chroma times coefficient, arithmetic shift right by 8 (floor)
    function automatic logic signed [8:0] scale_chroma(input logic signed [8:0] c,
                                                      input logic [7:0] k);
        logic signed [17:0] prod;
        logic signed [17:0] shifted;
        prod    = 18'(c) * 18'($signed({1'b0, k}));
        shifted = prod >>> 8;
        return shifted[8:0];
    endfunction

    // saturate a signed sum into a byte
    function automatic logic [7:0] clamp_byte(input logic signed [10:0] x);
        logic [7:0] res;
        if (x[10])
            res = '0;
        else if (x > $signed({3'b000, BYTE_MAX}))
            res = BYTE_MAX;
        else
            res = x[7:0];
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: src/nv21_to_rgb24_pixel_converter_core.sv
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    luma_sample, chroma_v, chroma_u
// out       output     out_valid / out_ready  red_value, green_value, blue_value,
//                                             pixel_index, frame_last
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one word per cycle sustained unless out_ready stalls the output; stage one registers
// the taken word with its position, stage two does the color math and the row times
// width multiply into the output register
// reset clears both counters and restores width 640, height 480, mirror on
// in_ready drops only when both stages hold words and out_ready is low
// cfg_ready is always high
`default_nettype none

module nv21_to_rgb24_pixel_converter_core #(
    parameter int unsigned MAX_WIDTH  = 2048,
    parameter int unsigned MAX_HEIGHT = 2048
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [7:0]                     luma_sample,
    input  wire logic [7:0]                     chroma_v,
    input  wire logic [7:0]                     chroma_u,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [7:0]                          red_value,
    output logic [7:0]                          green_value,
    output logic [7:0]                          blue_value,
    output logic [nv2rgb_pkg::INDEX_W-1:0]      pixel_index,
    output logic                                frame_last,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [nv2rgb_pkg::CFG_W-1:0]   cfg_data
);

    localparam int unsigned CB    = $clog2(MAX_WIDTH);
    localparam int unsigned EW    = $clog2(MAX_WIDTH + 1);
    localparam int unsigned RB    = $clog2(MAX_HEIGHT);
    localparam int unsigned EH    = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned CMPW  = (EW > nv2rgb_pkg::CFG_W) ? EW : nv2rgb_pkg::CFG_W;
    localparam int unsigned CMPH  = (EH > nv2rgb_pkg::CFG_W) ? EH : nv2rgb_pkg::CFG_W;
    localparam int unsigned SUM_W = RB + EW + 1;
    localparam int unsigned EXT_W = SUM_W + nv2rgb_pkg::INDEX_W;

    // configuration registers
    logic [nv2rgb_pkg::CFG_W-1:0] frame_width_reg;
    logic [nv2rgb_pkg::CFG_W-1:0] frame_width_next;
    logic [nv2rgb_pkg::CFG_W-1:0] frame_height_reg;
    logic [nv2rgb_pkg::CFG_W-1:0] frame_height_next;
    logic                         mirror_enable_reg;
    logic                         mirror_enable_next;

    // position counters
    logic [CB-1:0] col_reg;
    logic [CB-1:0] col_next;
    logic [RB-1:0] row_reg;
    logic [RB-1:0] row_next;

    // handshake state
    logic in_accept;
    logic out_load;
    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;

    // stage one payload
    logic [7:0]    s1_luma_reg;
    logic [7:0]    s1_v_reg;
    logic [7:0]    s1_u_reg;
    logic [RB-1:0] s1_row_reg;
    logic [EW-1:0] s1_width_reg;
    logic [CB-1:0] s1_col_reg;
    logic          s1_last_reg;

    // output payload
    logic [7:0]                     red_reg;
    logic [7:0]                     green_reg;
    logic [7:0]                     blue_reg;
    logic [nv2rgb_pkg::INDEX_W-1:0] index_reg;
    logic                           last_reg;

    // position logic
    logic [CMPW-1:0] width_ext;
    logic [CMPH-1:0] height_ext;
    logic [EW-1:0]   eff_w;
    logic [EH-1:0]   eff_h;
    logic [CB-1:0]   col_cur;
    logic [RB-1:0]   row_cur;
    logic [EW-1:0]   col_inc;
    logic [EH-1:0]   row_inc;
    logic            col_end;
    logic            row_end;
    logic [EW-1:0]   col_dst;

    // stage two math
    logic [7:0]                     red_next;
    logic [7:0]                     green_next;
    logic [7:0]                     blue_next;
    logic [RB+EW-1:0]               row_base;
    logic [SUM_W-1:0]               index_sum;
    logic [EXT_W-1:0]               index_ext;
    logic [nv2rgb_pkg::INDEX_W-1:0] index_next;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_comb
    begin
        frame_width_next   = frame_width_reg;
        frame_height_next  = frame_height_reg;
        mirror_enable_next = mirror_enable_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                nv2rgb_pkg::CFG_FRAME_WIDTH:   frame_width_next   = cfg_data;
                nv2rgb_pkg::CFG_FRAME_HEIGHT:  frame_height_next  = cfg_data;
                nv2rgb_pkg::CFG_MIRROR_ENABLE: mirror_enable_next = cfg_data[0];
                default:                       frame_width_next   = frame_width_reg;
            endcase
        end
    end

    // effective frame size: zero reads as one, oversize saturates
    assign width_ext  = CMPW'(frame_width_reg);
    assign height_ext = CMPH'(frame_height_reg);

    always_comb
    begin
        if (frame_width_reg == '0)
            eff_w = EW'(1);
        else if (width_ext > CMPW'(MAX_WIDTH))
            eff_w = EW'(MAX_WIDTH);
        else
            eff_w = width_ext[EW-1:0];

        if (frame_height_reg == '0)
            eff_h = EH'(1);
        else if (height_ext > CMPH'(MAX_HEIGHT))
            eff_h = EH'(MAX_HEIGHT);
        else
            eff_h = height_ext[EH-1:0];
    end

    // current position, restarting when the frame shrank under the counters
    assign col_cur = (EW'(col_reg) >= eff_w) ? '0 : col_reg;
    assign row_cur = (EH'(row_reg) >= eff_h) ? '0 : row_reg;
    assign col_inc = EW'(col_cur) + EW'(1);
    assign row_inc = EH'(row_cur) + EH'(1);
    assign col_end = (col_inc >= eff_w);
    assign row_end = (row_inc >= eff_h);

    // destination column, reversed within the row when mirroring
    assign col_dst = mirror_enable_reg ? (eff_w - EW'(1) - EW'(col_cur)) : EW'(col_cur);

    // counter advance per accepted word
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_accept)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_inc[RB-1:0];
            end
            else
            begin
                col_next = col_inc[CB-1:0];
                row_next = row_cur;
            end
        end
    end

    // two-stage pipeline handshake
    assign out_load  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || out_load;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (out_load)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= nv2rgb_pkg::FRAME_WIDTH_RESET;
            frame_height_reg  <= nv2rgb_pkg::FRAME_HEIGHT_RESET;
            mirror_enable_reg <= nv2rgb_pkg::MIRROR_RESET;
            col_reg           <= '0;
            row_reg           <= '0;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            frame_width_reg   <= frame_width_next;
            frame_height_reg  <= frame_height_next;
            mirror_enable_reg <= mirror_enable_next;
            col_reg           <= col_next;
            row_reg           <= row_next;
            s1_valid_reg      <= s1_valid_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // stage one capture
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_luma_reg  <= luma_sample;
            s1_v_reg     <= chroma_v;
            s1_u_reg     <= chroma_u;
            s1_row_reg   <= row_cur;
            s1_width_reg <= eff_w;
            s1_col_reg   <= col_dst[CB-1:0];
            s1_last_reg  <= col_end && row_end;
        end
    end

    // color conversion
    nv2rgb_color u_color (
        .luma_sample (s1_luma_reg),
        .chroma_v    (s1_v_reg),
        .chroma_u    (s1_u_reg),
        .red_value   (red_next),
        .green_value (green_next),
        .blue_value  (blue_next)
    );

    // destination index, kept to the port width
    assign row_base   = (RB+EW)'(s1_row_reg) * (RB+EW)'(s1_width_reg);
    assign index_sum  = SUM_W'(row_base) + SUM_W'(s1_col_reg);
    assign index_ext  = EXT_W'(index_sum);
    assign index_next = index_ext[nv2rgb_pkg::INDEX_W-1:0];

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            index_reg <= index_next;
            last_reg  <= s1_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign red_value   = red_reg;
    assign green_value = green_reg;
    assign blue_value  = blue_reg;
    assign pixel_index = index_reg;
    assign frame_last  = last_reg;

    // a word parked in stage one stays there with its position
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_load) |=> (s1_valid_reg && $stable(s1_row_reg)
                                         && $stable(s1_col_reg)))
        else $error("stage one word lost or changed while stalled");

    // the stored destination column lies inside the row
    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (EW'(s1_col_reg) < s1_width_reg))
        else $error("destination column outside the row");

    // the last word of a frame returns both counters to the origin
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && col_end && row_end) |=> (col_reg == '0 && row_reg == '0))
        else $error("counters did not wrap after the last pixel");

    // counters move only on an accepted word
    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> ($stable(col_reg) && $stable(row_reg)))
        else $error("counters moved without an accepted word");

endmodule

`default_nettype wire

FILE: src/nv2rgb_color.sv
`default_nettype none

module nv2rgb_color (
    input  wire logic [7:0] luma_sample,
    input  wire logic [7:0] chroma_v,
    input  wire logic [7:0] chroma_u,
    output logic [7:0]      red_value,
    output logic [7:0]      green_value,
    output logic [7:0]      blue_value
);

    logic [7:0]         y_off;
    logic [8:0]         v_raw;
    logic [8:0]         u_raw;
    logic signed [8:0]  v_s;
    logic signed [8:0]  u_s;
    logic signed [8:0]  v_red;
    logic signed [8:0]  v_green;
    logic signed [8:0]  u_green;
    logic signed [8:0]  u_blue;
    logic signed [10:0] y_e;
    logic signed [10:0] red_sum;
    logic signed [10:0] green_sum;
    logic signed [10:0] blue_sum;

    // luma minus black level, floored at zero
    assign y_off = (luma_sample < nv2rgb_pkg::LUMA_OFFSET) ? 8'd0
                 : (luma_sample - nv2rgb_pkg::LUMA_OFFSET);
    assign y_e   = $signed({3'b000, y_off});

    // chroma bytes to signed offsets
    assign v_raw = {1'b0, chroma_v} - nv2rgb_pkg::CHROMA_OFFSET;
    assign u_raw = {1'b0, chroma_u} - nv2rgb_pkg::CHROMA_OFFSET;
    assign v_s   = $signed(v_raw);
    assign u_s   = $signed(u_raw);

    // chroma terms
    assign v_red   = nv2rgb_pkg::scale_chroma(v_s, nv2rgb_pkg::K_V_RED);
    assign v_green = nv2rgb_pkg::scale_chroma(v_s, nv2rgb_pkg::K_V_GREEN);
    assign u_green = nv2rgb_pkg::scale_chroma(u_s, nv2rgb_pkg::K_U_GREEN);
    assign u_blue  = nv2rgb_pkg::scale_chroma(u_s, nv2rgb_pkg::K_U_BLUE);

    // component sums
    assign red_sum   = y_e + {{2{v_s[8]}}, v_s} + {{2{v_red[8]}}, v_red};
    assign green_sum = y_e - {{2{v_green[8]}}, v_green} - {{2{u_green[8]}}, u_green};
    assign blue_sum  = y_e + {{2{u_s[8]}}, u_s} + {{2{u_blue[8]}}, u_blue};

    // saturate to bytes
    assign red_value   = nv2rgb_pkg::clamp_byte(red_sum);
    assign green_value = nv2rgb_pkg::clamp_byte(green_sum);
    assign blue_value  = nv2rgb_pkg::clamp_byte(blue_sum);

endmodule

`default_nettype wire
